FILE: hdl/ogrt_pkg.sv
//==============================================================================
// ogrt_pkg
// Shared types and codes for the occupancy grid ray tracer.
//==============================================================================
`default_nettype none

package ogrt_pkg;

    // Request codes.
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_OCC   = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // Cell codes.
    localparam logic [1:0] CELL_UNKNOWN = 2'd0;
    localparam logic [1:0] CELL_FREE    = 2'd1;
    localparam logic [1:0] CELL_OCC     = 2'd2;

    // Written-cell counter limit and the side used after reset.
    localparam logic [11:0] WRITE_MAX      = 12'd4095;
    localparam logic [9:0]  MAP_SIDE_RESET = 10'd400;

    // Register indexes of the configuration port.
    localparam logic REG_MAP_SIDE = 1'b0;

    // Sequencer states.
    typedef enum logic [7:0] {
        ST_CLR  = 8'b0000_0001,
        ST_IDLE = 8'b0000_0010,
        ST_ADDR = 8'b0000_0100,
        ST_RD   = 8'b0000_1000,
        ST_CHK  = 8'b0001_0000,
        ST_NB   = 8'b0010_0000,
        ST_ADV  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

endpackage

`default_nettype wire

FILE: hdl/ogrt_ram.sv
//==============================================================================
// ogrt_ram
// Single-port synchronous RAM with a registered read.
//==============================================================================
`default_nettype none

module ogrt_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 262144
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one word each cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

FILE: hdl/occupancy_grid_ray_tracer.sv
//==============================================================================
// occupancy_grid_ray_tracer
// Occupancy grid with Bresenham ray marking, clear and cell read.
//==============================================================================
// Channel   | Signals                                   | Word
// ----------+-------------------------------------------+----------------------
// input     | in_valid, in_ready                        | request and endpoints
// output    | out_valid, out_ready                      | state, count, stop
// config    | psel, penable, pwrite, paddr, pwdata, ... | map_side at 0x0
//
// The grid lives in one single-port RAM, so one access is made at a time.
// A free ray also reads the nine neighbors of each in-grid cell.
// After reset and on a clear request the RAM is swept one cell per cycle,
// while no word is accepted.
// A new word is accepted while a finished result waits in the output register.
//==============================================================================
`default_nettype none

module occupancy_grid_ray_tracer #(
    parameter int GRID_SIDE  = 512,
    parameter int COORD_BITS = 12
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   req_type,
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [1:0]                        cell_state,
    output logic [11:0]                       cells_written,
    output logic                              stopped_early,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(GRID_SIDE + 1);
    localparam int CW    = COORD_BITS;
    localparam int EW    = CW + 2;
    localparam int PW    = ((CW > SW) ? CW : SW) + 2;
    localparam logic [SW-1:0] SIDE_MAX = SW'(GRID_SIDE);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    ogrt_pkg::state_t state_reg, state_next;

    logic [9:0]           map_side_reg;
    logic [SW-1:0]        side_used;
    logic [SW-1:0]        side_reg;
    logic [1:0]           req_reg;
    logic signed [CW-1:0] x_reg, y_reg, x1_reg, y1_reg;
    logic signed [EW-1:0] dx_reg, dy_reg, err_reg;
    logic                 sx_neg_reg, sy_neg_reg;
    logic [AW-1:0]        caddr_reg;
    logic [AW-1:0]        clr_reg;
    logic                 clr_req_reg;
    logic [3:0]           k_reg;
    logic                 pend_reg;
    logic [1:0]           st_reg;
    logic [11:0]          cnt_reg;
    logic                 stop_reg;

    logic                 out_valid_reg;
    logic [1:0]           cell_state_reg;
    logic [11:0]          cells_written_reg;
    logic                 stopped_early_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [1:0]           ram_wdata;
    logic [1:0]           ram_rdata;

    logic                 cfg_wr;
    logic                 in_acc;
    logic                 out_load;
    logic                 at_end;
    logic                 on_grid;
    logic signed [PW-1:0] px, py, sp;
    logic [2*SW-1:0]      prod;
    logic signed [EW:0]   e2;
    logic signed [EW-1:0] ddx, ddy;
    logic signed [1:0]    nb_dx, nb_dy;
    logic signed [PW-1:0] nx, ny;
    logic                 nb_on;
    logic signed [AW+1:0] nb_off, nb_addr;
    logic                 chk_write;
    logic [1:0]           chk_val;

    // Configuration port: writes complete in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == ogrt_pkg::REG_MAP_SIDE) ? {22'd0, map_side_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_side_reg <= ogrt_pkg::MAP_SIDE_RESET;
        end
        else if (cfg_wr && paddr[2] == ogrt_pkg::REG_MAP_SIDE)
        begin
            map_side_reg <= pwdata[9:0];
        end
    end

    // Side in use, limited to the grid storage.
    assign side_used = ({{(SW > 10 ? 1 : 11 - SW){1'b0}}, map_side_reg} > PW'(SIDE_MAX))
                       ? SIDE_MAX : SW'(map_side_reg);

    // Current point tests and its cell address.
    assign px      = PW'(x_reg);
    assign py      = PW'(y_reg);
    assign sp      = PW'({1'b0, side_reg});
    assign on_grid = (px >= 0) && (px < sp) && (py >= 0) && (py < sp);
    assign prod    = SW'(y_reg) * side_reg;
    assign at_end  = (x_reg == x1_reg) && (y_reg == y1_reg);
    assign e2      = {err_reg, 1'b0};

    // Endpoint differences at accept.
    assign ddx = EW'(end_x) - EW'(start_x);
    assign ddy = EW'(end_y) - EW'(start_y);

    // Neighbor offsets in raster order over the 3x3 window.
    always_comb
    begin
        unique case (k_reg)
            4'd0, 4'd1, 4'd2: nb_dy = -2'sd1;
            4'd3, 4'd4, 4'd5: nb_dy =  2'sd0;
            default:          nb_dy =  2'sd1;
        endcase
        unique case (k_reg)
            4'd0, 4'd3, 4'd6: nb_dx = -2'sd1;
            4'd1, 4'd4, 4'd7: nb_dx =  2'sd0;
            default:          nb_dx =  2'sd1;
        endcase
    end

    assign nx      = px + PW'(nb_dx);
    assign ny      = py + PW'(nb_dy);
    assign nb_on   = (k_reg < 4'd9) && (nx >= 0) && (nx < sp) && (ny >= 0) && (ny < sp);
    assign nb_off  = ((nb_dy < 0) ? -(AW+2)'({1'b0, side_reg})
                   : (nb_dy > 0) ?  (AW+2)'({1'b0, side_reg}) : '0) + (AW+2)'(nb_dx);
    assign nb_addr = $signed({2'b00, caddr_reg}) + nb_off;

    // Cell update for the current ray point.
    always_comb
    begin
        chk_write = 1'b0;
        chk_val   = ogrt_pkg::CELL_FREE;
        if (at_end && req_reg == ogrt_pkg::REQ_OCC)
        begin
            chk_write = (ram_rdata != ogrt_pkg::CELL_OCC);
            chk_val   = ogrt_pkg::CELL_OCC;
        end
        else if (!at_end)
        begin
            chk_write = (ram_rdata != ogrt_pkg::CELL_OCC) && (ram_rdata != ogrt_pkg::CELL_FREE);
        end
    end

    // RAM port selection.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = caddr_reg;
        ram_wdata = chk_val;
        unique case (state_reg)
            ogrt_pkg::ST_CLR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = ogrt_pkg::CELL_UNKNOWN;
            end
            ogrt_pkg::ST_CHK:
            begin
                ram_we = (req_reg != ogrt_pkg::REQ_READ) && chk_write;
            end
            ogrt_pkg::ST_NB:
            begin
                ram_addr = nb_addr[AW-1:0];
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    ogrt_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign in_ready = (state_reg == ogrt_pkg::ST_IDLE);
    assign in_acc   = in_valid & in_ready;
    assign out_load = (state_reg == ogrt_pkg::ST_DONE) && (!out_valid_reg || out_ready);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ogrt_pkg::ST_CLR:
            begin
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = clr_req_reg ? ogrt_pkg::ST_DONE : ogrt_pkg::ST_IDLE;
                end
            end
            ogrt_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (req_type == ogrt_pkg::REQ_CLEAR)
                                 ? ogrt_pkg::ST_CLR : ogrt_pkg::ST_ADDR;
                end
            end
            ogrt_pkg::ST_ADDR:
            begin
                if (on_grid)
                    state_next = ogrt_pkg::ST_RD;
                else if (req_reg == ogrt_pkg::REQ_READ)
                    state_next = ogrt_pkg::ST_DONE;
                else
                    state_next = ogrt_pkg::ST_ADV;
            end
            ogrt_pkg::ST_RD:
            begin
                state_next = ogrt_pkg::ST_CHK;
            end
            ogrt_pkg::ST_CHK:
            begin
                if (req_reg == ogrt_pkg::REQ_READ)
                    state_next = ogrt_pkg::ST_DONE;
                else if (req_reg == ogrt_pkg::REQ_FREE)
                    state_next = ogrt_pkg::ST_NB;
                else
                    state_next = ogrt_pkg::ST_ADV;
            end
            ogrt_pkg::ST_NB:
            begin
                if (pend_reg && ram_rdata == ogrt_pkg::CELL_OCC)
                    state_next = ogrt_pkg::ST_DONE;
                else if (k_reg == 4'd9)
                    state_next = ogrt_pkg::ST_ADV;
            end
            ogrt_pkg::ST_ADV:
            begin
                state_next = at_end ? ogrt_pkg::ST_DONE : ogrt_pkg::ST_ADDR;
            end
            ogrt_pkg::ST_DONE:
            begin
                if (out_load)
                    state_next = ogrt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ogrt_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers. The sweep address returns to zero after the last cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ogrt_pkg::ST_CLR;
            clr_reg       <= '0;
            clr_req_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ogrt_pkg::ST_CLR)
                clr_reg <= (clr_reg == LAST_ADDR) ? '0 : clr_reg + 1'b1;
            if (in_acc)
                clr_req_reg <= (req_type == ogrt_pkg::REQ_CLEAR);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Ray walk registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg    <= req_type;
            side_reg   <= side_used;
            x_reg      <= start_x;
            y_reg      <= start_y;
            x1_reg     <= end_x;
            y1_reg     <= end_y;
            dx_reg     <= ddx[EW-1] ? -ddx : ddx;
            dy_reg     <= ddy[EW-1] ? -ddy : ddy;
            err_reg    <= (ddx[EW-1] ? -ddx : ddx) - (ddy[EW-1] ? -ddy : ddy);
            sx_neg_reg <= !(start_x < end_x);
            sy_neg_reg <= !(start_y < end_y);
            st_reg     <= ogrt_pkg::CELL_UNKNOWN;
            cnt_reg    <= '0;
            stop_reg   <= 1'b0;
        end
        unique case (state_reg)
            ogrt_pkg::ST_ADDR:
            begin
                caddr_reg <= AW'(prod + (2*SW)'(SW'(x_reg)));
            end
            ogrt_pkg::ST_CHK:
            begin
                k_reg    <= '0;
                pend_reg <= 1'b0;
                if (req_reg == ogrt_pkg::REQ_READ)
                    st_reg <= ram_rdata;
                else if (chk_write && cnt_reg != ogrt_pkg::WRITE_MAX)
                    cnt_reg <= cnt_reg + 1'b1;
            end
            ogrt_pkg::ST_NB:
            begin
                k_reg    <= k_reg + 1'b1;
                pend_reg <= nb_on;
                if (pend_reg && ram_rdata == ogrt_pkg::CELL_OCC)
                    stop_reg <= 1'b1;
            end
            ogrt_pkg::ST_ADV:
            begin
                if (!at_end)
                begin
                    if (e2 > -(EW+1)'(dy_reg) && e2 < (EW+1)'(dx_reg))
                    begin
                        err_reg <= err_reg - dy_reg + dx_reg;
                        x_reg   <= sx_neg_reg ? x_reg - 1'b1 : x_reg + 1'b1;
                        y_reg   <= sy_neg_reg ? y_reg - 1'b1 : y_reg + 1'b1;
                    end
                    else if (e2 > -(EW+1)'(dy_reg))
                    begin
                        err_reg <= err_reg - dy_reg;
                        x_reg   <= sx_neg_reg ? x_reg - 1'b1 : x_reg + 1'b1;
                    end
                    else if (e2 < (EW+1)'(dx_reg))
                    begin
                        err_reg <= err_reg + dx_reg;
                        y_reg   <= sy_neg_reg ? y_reg - 1'b1 : y_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            cell_state_reg    <= st_reg;
            cells_written_reg <= cnt_reg;
            stopped_early_reg <= stop_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cell_state    = cell_state_reg;
    assign cells_written = cells_written_reg;
    assign stopped_early = stopped_early_reg;

`ifndef SYNTHESIS
    // No word is taken while the grid is being swept.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ogrt_pkg::ST_CLR) |-> !in_ready)
        else $error("word accepted during grid sweep");

    // The grid is written only by the sweep or the cell update step.
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ogrt_pkg::ST_CLR || state_reg == ogrt_pkg::ST_CHK))
        else $error("grid written outside sweep or update");

    // A read result never carries a ray count or a stop flag.
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cell_state != ogrt_pkg::CELL_UNKNOWN)
        |-> (cells_written == 12'd0 && !stopped_early))
        else $error("read result mixed with ray result");

    // A result is loaded only when the output slot is free or being taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && state_reg == ogrt_pkg::ST_DONE)
        |=> (state_reg == ogrt_pkg::ST_DONE))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_occupancy_grid_ray_tracer.sv
//==============================================================================
// tb_occupancy_grid_ray_tracer
// Self-checking bench for the occupancy grid ray tracer. Requests go in over
// the valid/ready input channel and results come back on the output channel.
// A scoreboard keeps its own copy of the grid, predicts every result and
// checks results in order. The map side is changed over the configuration
// port between phases of random rays and reads.
//==============================================================================
`default_nettype none

class grid_scoreboard;

    typedef struct {
        logic [1:0]  state;
        logic [11:0] count;
        logic        stop;
    } result_t;

    bit [1:0] cells[512*512];
    int       side_reg;
    result_t  pending[$];
    int       errors;

    function new();
        foreach (cells[i]) cells[i] = ogrt_pkg::CELL_UNKNOWN;
        side_reg = int'(ogrt_pkg::MAP_SIDE_RESET);
        errors   = 0;
    endfunction

    function void set_side(int v);
        side_reg = v;
    endfunction

    function int side_eff();
        return (side_reg > 512) ? 512 : side_reg;
    endfunction

    function bit in_map(int x, int y, int s);
        return x >= 0 && x < s && y >= 0 && y < s;
    endfunction

    // Any occupied cell in the 3x3 block around (x, y), the cell included.
    function bit near_occ(int x, int y, int s);
        for (int i = -1; i <= 1; i++)
            for (int j = -1; j <= 1; j++)
                if (in_map(x + i, y + j, s) &&
                    cells[(y + j) * s + x + i] == ogrt_pkg::CELL_OCC)
                    return 1;
        return 0;
    endfunction

    // Bresenham walk; marks cells and returns the changed-cell count.
    function void cast_ray(int x0, int y0, int x1, int y1, bit mark_end,
                           output int written, output bit stopped);
        int s, dx, dy, stx, sty, err, e2, k;
        bit at_end;
        s = side_eff();
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        stx = (x0 < x1) ? 1 : -1;
        sty = (y0 < y1) ? 1 : -1;
        err = dx - dy;
        written = 0;
        stopped = 0;
        forever
        begin
            at_end = (x0 == x1 && y0 == y1);
            if (in_map(x0, y0, s))
            begin
                k = y0 * s + x0;
                if (at_end && mark_end)
                begin
                    if (cells[k] != ogrt_pkg::CELL_OCC)
                    begin
                        cells[k] = ogrt_pkg::CELL_OCC;
                        written++;
                    end
                end
                else if (!at_end && cells[k] == ogrt_pkg::CELL_UNKNOWN)
                begin
                    cells[k] = ogrt_pkg::CELL_FREE;
                    written++;
                end
                if (!mark_end && near_occ(x0, y0, s))
                begin
                    stopped = 1;
                    break;
                end
            end
            if (at_end) break;
            e2 = 2 * err;
            if (e2 > -dy)
            begin
                err -= dy;
                x0 += stx;
            end
            if (e2 < dx)
            begin
                err += dx;
                y0 += sty;
            end
        end
        if (written > 4095) written = 4095;
    endfunction

    // Note an accepted request word and queue its expected result.
    function void note_request(logic [1:0] req, int x0, int y0, int x1, int y1);
        result_t r;
        int w;
        bit st;
        r = '{ogrt_pkg::CELL_UNKNOWN, 12'd0, 1'b0};
        case (req)
            ogrt_pkg::REQ_CLEAR: foreach (cells[i]) cells[i] = ogrt_pkg::CELL_UNKNOWN;
            ogrt_pkg::REQ_OCC, ogrt_pkg::REQ_FREE:
            begin
                cast_ray(x0, y0, x1, y1, req == ogrt_pkg::REQ_OCC, w, st);
                r.count = 12'(w);
                r.stop  = st;
            end
            default: if (in_map(x0, y0, side_eff()))
                r.state = cells[y0 * side_eff() + x0];
        endcase
        pending.push_back(r);
    endfunction

    // Compare one result word with the oldest expectation.
    function void check_result(logic [1:0] st, logic [11:0] cnt, logic stp);
        result_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result word state=%0d count=%0d stop=%0d",
                     $time, st, cnt, stp);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (st !== e.state)
        begin
            $display("%0t: cell_state expected %0d actual %0d", $time, e.state, st);
            errors++;
        end
        if (cnt !== e.count)
        begin
            $display("%0t: cells_written expected %0d actual %0d", $time, e.count, cnt);
            errors++;
        end
        if (stp !== e.stop)
        begin
            $display("%0t: stopped_early expected %0d actual %0d", $time, e.stop, stp);
            errors++;
        end
    endfunction
endclass

module tb_occupancy_grid_ray_tracer;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1500000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [11:0] start_x;
    logic [11:0] start_y;
    logic [11:0] end_x;
    logic [11:0] end_y;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  cell_state;
    logic [11:0] cells_written;
    logic        stopped_early;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    grid_scoreboard sb = new();
    bit  calm;
    int  quiet_cycles;

    occupancy_grid_ray_tracer dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .start_x(start_x), .start_y(start_y),
        .end_x(end_x), .end_y(end_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .cell_state(cell_state), .cells_written(cells_written),
        .stopped_early(stopped_early),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Clock with a 2 ns period.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result side: random stalls, checking, and the no-progress watchdog.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_result(cell_state, cells_written, stopped_early);
        if ((out_valid && out_ready) || (in_valid && in_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        out_ready <= calm || ($urandom_range(99) >= 11);
    end

    // Send one request word, with a random idle gap before it.
    task automatic send_word(logic [1:0] req, int x0, int y0, int x1, int y1);
        while (!calm && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        start_x  <= 12'(x0);
        start_y  <= 12'(y0);
        end_x    <= 12'(x1);
        end_y    <= 12'(y1);
        do @(posedge clk); while (!in_ready);
        sb.note_request(req, x0, y0, x1, y1);
    endtask

    // Let every expected result drain, then a few spare cycles.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Write the map side register with a setup phase and then an access phase.
    task automatic write_side(int v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(4 * ogrt_pkg::REG_MAP_SIDE);
        pwdata  <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_side(v);
        @(posedge clk);
    endtask

    // Coordinate around the grid in use, a few cells beyond each edge.
    function automatic int near_coord(int s);
        return int'($urandom_range(s + 5)) - 3;
    endfunction

    task automatic random_word(int s);
        int pick, x0, y0, x1, y1;
        logic [1:0] req;
        pick = $urandom_range(99);
        req = (pick < 42) ? ogrt_pkg::REQ_OCC
            : (pick < 78) ? ogrt_pkg::REQ_FREE : ogrt_pkg::REQ_READ;
        if ($urandom_range(99) < 8)
        begin
            x0 = int'($signed(12'($urandom_range(4095))));
            y0 = int'($signed(12'($urandom_range(4095))));
            x1 = int'($signed(12'($urandom_range(4095))));
            y1 = int'($signed(12'($urandom_range(4095))));
        end
        else
        begin
            x0 = near_coord(s);
            y0 = near_coord(s);
            if ($urandom_range(99) < 85)
            begin
                x1 = x0 + int'($urandom_range(24)) - 12;
                y1 = y0 + int'($urandom_range(24)) - 12;
            end
            else
            begin
                x1 = near_coord(s);
                y1 = near_coord(s);
            end
        end
        send_word(req, x0, y0, x1, y1);
    endtask

    int sides[8] = '{16, 1, 0, 512, 1023, 37, 400, 23};

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        req_type  = ogrt_pkg::REQ_READ;
        start_x   = '0;
        start_y   = '0;
        end_x     = '0;
        end_y     = '0;
        out_ready = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        calm      = 1'b0;
        quiet_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset side of 400.
        send_word(ogrt_pkg::REQ_READ, 0, 0, 0, 0);
        send_word(ogrt_pkg::REQ_OCC, 0, 0, 10, 3);
        send_word(ogrt_pkg::REQ_READ, 10, 3, 0, 0);
        send_word(ogrt_pkg::REQ_READ, 5, 1, 0, 0);
        send_word(ogrt_pkg::REQ_FREE, 0, 0, 10, 3);
        send_word(ogrt_pkg::REQ_FREE, 100, 100, 120, 90);
        send_word(ogrt_pkg::REQ_FREE, 100, 100, 120, 90);
        send_word(ogrt_pkg::REQ_READ, -1, 5, 0, 0);
        send_word(ogrt_pkg::REQ_READ, 400, 0, 0, 0);
        send_word(ogrt_pkg::REQ_READ, 399, 399, 0, 0);
        send_word(ogrt_pkg::REQ_OCC, -2048, -2048, 2047, 2047);
        send_word(ogrt_pkg::REQ_OCC, 2047, -2048, -2048, 2047);
        send_word(ogrt_pkg::REQ_OCC, 50, 50, 50, 50);
        send_word(ogrt_pkg::REQ_FREE, 60, 60, 60, 60);
        send_word(ogrt_pkg::REQ_OCC, 210, 200, 205, 200);
        send_word(ogrt_pkg::REQ_FREE, 300, 200, 206, 200);
        send_word(ogrt_pkg::REQ_OCC, 0, 0, 10, 3);
        send_word(ogrt_pkg::REQ_FREE, -5, 30, 2047, 30);
        send_word(ogrt_pkg::REQ_READ, 2047, -2048, 0, 0);
        send_word(ogrt_pkg::REQ_CLEAR, 0, 0, 0, 0);
        send_word(ogrt_pkg::REQ_READ, 10, 3, 0, 0);
        drain();

        // Random phases, each under its own map side.
        foreach (sides[p])
        begin
            write_side(sides[p]);
            calm = (p == 1);
            for (int n = 0; n < 235; n++)
            begin
                if (p == 0 && n == 120)
                    send_word(ogrt_pkg::REQ_CLEAR, 0, 0, 0, 0);
                random_word((sides[p] > 512) ? 512 : sides[p]);
            end
            drain();
        end

        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

`default_nettype wire
